@@ rtl/canac_pkg.sv @@
// Package for the address-claim block: word types, protocol constants and status codes.
// Used by the top level can_address_claim and by its checker canac_chk.
`timescale 1ns / 1ps

package canac_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Status codes of a result word; the first five are also the phase codes.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLAIMING = 3'd1;
    localparam logic [2:0] ST_CLAIMED  = 3'd2;
    localparam logic [2:0] ST_CONFLICT = 3'd3;
    localparam logic [2:0] ST_NOADDR   = 3'd4;
    localparam logic [2:0] ST_BUSY     = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_OWN_NAME = 1'b0;
    localparam logic CFG_WINDOW   = 1'b1;

    // Frame constants.
    localparam logic [7:0]  CLAIM_FORMAT  = 8'hEE;
    localparam logic [7:0]  NULL_ADDR     = 8'd254;
    localparam logic [7:0]  LAST_ADDR     = 8'd251;
    localparam logic [28:0] CLAIM_ID_BASE = 29'h18EE_FF00;
    localparam logic [15:0] WINDOW_RESET  = 16'd250;

    // Input word.
    typedef struct packed {
        logic [1:0]  operation;
        logic [28:0] rx_identifier;
        logic [63:0] rx_payload;
    } item_t;

    // Result word.
    typedef struct packed {
        logic        send_valid;
        logic [28:0] send_identifier;
        logic [63:0] send_payload;
        logic [2:0]  status;
        logic [7:0]  held_address;
    } result_t;

endpackage

@@ rtl/can_address_claim.sv @@
// Address-claim sequencer: input register, one pass of compare/update logic, result register.
// Depends on canac_pkg for the word types, codes and frame constants.
// A word in the input register moves into the result register when the input stage advances.
// Throughput: one word per cycle while not stalled; the phase and window counter update in one pass.
// Reset (rst_n low, asynchronous): phase idle, addresses and window zero, name zero,
// window register 250, both pipeline stages empty.
`timescale 1ns / 1ps

module can_address_claim (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  canac_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output canac_pkg::result_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data
);

    // Reciprocal of 252 scaled by 2^29, for the start-address remainder.
    localparam logic [21:0] RECIP_252 = 22'd2130440;
    localparam int          RECIP_SHIFT = 29;

    // Configuration and derived registers.
    logic [63:0] own_name_reg;
    logic [15:0] window_ticks_reg;
    logic [7:0]  name_addr_reg;
    logic [7:0]  name_addr_next;

    // Claim state.
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  trial_reg, trial_next;
    logic [7:0]  first_reg, first_next;
    logic [15:0] window_reg, window_next;
    logic [7:0]  won_reg, won_next;

    // Pipeline stages.
    logic               s1_valid_reg;
    canac_pkg::item_t   s1_word_reg;
    logic               out_valid_reg;
    canac_pkg::result_t out_word_reg;
    canac_pkg::result_t out_word_next;
    logic               advance;

    // Remainder of name bits 20..0 by 252, captured when the name is written.
    logic [20:0] mod_x;
    logic [42:0] mod_prod;
    logic [13:0] mod_q;
    logic [21:0] mod_qm;
    logic [21:0] mod_r;

    assign mod_x    = cfg_data[20:0];
    assign mod_prod = 43'(mod_x) * 43'(RECIP_252);
    assign mod_q    = mod_prod[42:RECIP_SHIFT];
    assign mod_qm   = {mod_q, 8'd0} - {6'd0, mod_q, 2'd0};
    assign mod_r    = {1'b0, mod_x} - mod_qm;

    always_comb
    begin
        if (mod_r >= 22'd252)
        begin
            name_addr_next = 8'(mod_r - 22'd252);
        end
        else
        begin
            name_addr_next = mod_r[7:0];
        end
    end

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_name_reg     <= '0;
            window_ticks_reg <= canac_pkg::WINDOW_RESET;
            name_addr_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == canac_pkg::CFG_OWN_NAME)
            begin
                own_name_reg  <= cfg_data;
                name_addr_reg <= name_addr_next;
            end
            else
            begin
                window_ticks_reg <= cfg_data[15:0];
            end
        end
    end

    // Handshake: the input stage moves on when the result register is free or being taken.
    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;

    // Claim logic for the word in the input stage.
    logic        busy;
    logic        send;
    logic [7:0]  source;
    logic        frame_hit;
    logic [7:0]  trial_inc;
    logic [15:0] window_open;

    always_comb
    begin
        window_open = (window_ticks_reg == 16'd0) ? 16'd1 : window_ticks_reg;
        trial_inc   = (trial_reg == canac_pkg::LAST_ADDR) ? 8'd0 : trial_reg + 8'd1;
        frame_hit   = (phase_reg == canac_pkg::ST_CLAIMING)
                   && (s1_word_reg.rx_identifier[23:16] == canac_pkg::CLAIM_FORMAT)
                   && (s1_word_reg.rx_identifier[7:0] == trial_reg)
                   && (s1_word_reg.rx_payload < own_name_reg);

        phase_next  = phase_reg;
        trial_next  = trial_reg;
        first_next  = first_reg;
        window_next = window_reg;
        won_next    = won_reg;
        busy        = 1'b0;
        send        = 1'b0;
        source      = 8'd0;

        case (s1_word_reg.operation)
            canac_pkg::OP_START:
            begin
                if (phase_reg == canac_pkg::ST_CLAIMING)
                begin
                    busy = 1'b1;
                end
                else
                begin
                    first_next  = name_addr_reg;
                    trial_next  = name_addr_reg;
                    phase_next  = canac_pkg::ST_CLAIMING;
                    window_next = window_open;
                    send        = 1'b1;
                    source      = name_addr_reg;
                end
            end
            canac_pkg::OP_FRAME:
            begin
                if (frame_hit)
                begin
                    if (own_name_reg[63])
                    begin
                        trial_next = trial_inc;
                        if (trial_inc == first_reg)
                        begin
                            phase_next = canac_pkg::ST_NOADDR;
                        end
                        else
                        begin
                            window_next = window_open;
                            send        = 1'b1;
                            source      = trial_inc;
                        end
                    end
                    else
                    begin
                        phase_next = canac_pkg::ST_CONFLICT;
                        send       = 1'b1;
                        source     = canac_pkg::NULL_ADDR;
                    end
                end
            end
            canac_pkg::OP_TICK:
            begin
                if (phase_reg == canac_pkg::ST_CLAIMING)
                begin
                    if (window_reg <= 16'd1)
                    begin
                        window_next = 16'd0;
                        won_next    = trial_reg;
                        phase_next  = canac_pkg::ST_CLAIMED;
                    end
                    else
                    begin
                        window_next = window_reg - 16'd1;
                    end
                end
            end
            default:
            begin
                // Undefined operation: state holds, current status is reported.
            end
        endcase

        out_word_next.send_valid      = send;
        out_word_next.send_identifier = send ? (canac_pkg::CLAIM_ID_BASE | {21'd0, source})
                                             : 29'd0;
        out_word_next.send_payload    = send ? own_name_reg : 64'd0;
        out_word_next.status          = busy ? canac_pkg::ST_BUSY : phase_next;
        out_word_next.held_address    = (phase_next == canac_pkg::ST_CLAIMED && !busy)
                                        ? won_next : 8'd0;
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_word_reg <= item;
        end
    end

    // Claim state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= canac_pkg::ST_IDLE;
            trial_reg     <= '0;
            first_reg     <= '0;
            window_reg    <= '0;
            won_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg  <= phase_next;
                trial_reg  <= trial_next;
                first_reg  <= first_next;
                window_reg <= window_next;
                won_reg    <= won_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

@@ rtl/canac_chk.sv @@
// Port-level checker for can_address_claim, attached by the bind statement at the end.
// Depends on canac_pkg for the word types and codes.
`timescale 1ns / 1ps

module canac_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input canac_pkg::result_t result
);

    // A stalled result word stays and does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result word changed");

    // With no frame to send, identifier and payload are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.send_valid |->
            result.send_identifier == 29'd0 && result.send_payload == 64'd0)
    else $error("frame fields set without a frame");

    // A sent frame always carries the claim priority, format and global destination.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.send_valid |->
            result.send_identifier[28:8] == canac_pkg::CLAIM_ID_BASE[28:8])
    else $error("claim identifier malformed");

    // A held address is reported only when claimed, and always lies in the address span.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.status == canac_pkg::ST_CLAIMED && result.held_address <= 8'd251)
            || result.held_address == 8'd0)
    else $error("held address outside claimed status or span");

    // A rejected start sends no frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == canac_pkg::ST_BUSY |-> !result.send_valid)
    else $error("frame sent on rejected start");

endmodule

bind can_address_claim canac_chk u_canac_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
